FILE: hdl/lambert_face_shading_top_assert.svh
// Assertion macros used by the shading block's controller
`ifndef LAMBERT_FACE_SHADING_TOP_ASSERT_SVH
`define LAMBERT_FACE_SHADING_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LFS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lambert_face_shading: assertion failed");

// Next-cycle implication, checked outside reset
`define LFS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lambert_face_shading: assertion failed");

`endif

FILE: hdl/lfs_pkg.sv
// Types and constants shared by the face shading controller and datapath
`timescale 1ns / 1ps

package lfs_pkg;

	localparam int NUM_LIGHT_REGS = 4;
	localparam int ONE_Q12        = 4096;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_LIGHT_COUNT = 3'd0;
	localparam logic [2:0] REG_CENTER_X    = 3'd1;
	localparam logic [2:0] REG_CENTER_Y    = 3'd2;
	localparam logic [2:0] REG_CENTER_Z    = 3'd3;
	localparam logic [2:0] REG_LIGHT_0     = 3'd4;
	localparam logic [2:0] REG_LIGHT_1     = 3'd5;
	localparam logic [2:0] REG_LIGHT_2     = 3'd6;
	localparam logic [2:0] REG_LIGHT_3     = 3'd7;

	// Last step of the multi-cycle units
	localparam logic [4:0] SQRT_LAST_STEP = 5'd24;
	localparam logic [4:0] DIV_LAST_STEP  = 5'd13;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CROSS,
		OP_FLIP,
		OP_LOADN,
		OP_LOADL,
		OP_SCALE,
		OP_SQ,
		OP_SQRT,
		OP_DOT,
		OP_DEN,
		OP_DIV,
		OP_ACC,
		OP_DEGEN
	} lfs_op_t;

	typedef struct packed {
		lfs_op_t    op;
		logic [4:0] step;
		logic       which;   // 0: face normal, 1: light vector
		logic [1:0] light;
	} lfs_cmd_t;

	typedef struct packed {
		logic in_range;
		logic nzero;
		logic rzero;
		logic lzero;
	} lfs_stat_t;

endpackage

FILE: hdl/lfs_dp.sv
// Datapath: shared multiplier, range scaler, square root and divider
`timescale 1ns / 1ps

module lfs_dp import lfs_pkg::*; (
	input  logic                    clk,
	input  lfs_cmd_t                cmd,
	output lfs_stat_t               stat,
	input  logic signed [15:0]      vert_a_x,
	input  logic signed [15:0]      vert_a_y,
	input  logic signed [15:0]      vert_a_z,
	input  logic signed [15:0]      vert_b_x,
	input  logic signed [15:0]      vert_b_y,
	input  logic signed [15:0]      vert_b_z,
	input  logic signed [15:0]      vert_c_x,
	input  logic signed [15:0]      vert_c_y,
	input  logic signed [15:0]      vert_c_z,
	input  logic signed [15:0]      center_x,
	input  logic signed [15:0]      center_y,
	input  logic signed [15:0]      center_z,
	input  logic [3:0][47:0]        light_pos,
	output logic signed [15:0]      intensity,
	output logic                    degenerate
);

	logic signed [15:0] a_q   [3];
	logic signed [16:0] e1_q  [3];
	logic signed [16:0] e2_q  [3];
	logic signed [16:0] r_q   [3];
	logic signed [34:0] n_q   [3];
	logic signed [35:0] vec_q [3];
	logic signed [23:0] ns_q  [3];
	logic signed [61:0] acc_q;
	logic               flip_q;
	logic [49:0]        sx_q, sr_q, sb_q;
	logic [24:0]        ln_q, ll_q;
	logic signed [49:0] dot_q;
	logic [61:0]        rem_q, dsh_q;
	logic [13:0]        quo_q;
	logic signed [17:0] sum_q;
	logic               degen_q;

	logic [1:0]         idx;
	logic signed [35:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [61:0] prod;
	logic               clr;
	logic signed [61:0] term;
	logic signed [61:0] acc_nxt;
	logic [35:0]        mag0, mag1, mag2, vmax;
	logic               v_lo, v_hi;
	logic [49:0]        sq_t, sr_nxt;
	logic               sq_ge;
	logic [47:0]        lp;
	logic [49:0]        dot_mag;
	logic [61:0]        den_u;
	logic [13:0]        q_clip;
	logic signed [49:0] dot_nxt;

	assign idx = cmd.step[1:0];

	// Select multiplier operands for the current operation
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_CROSS: begin
				case (cmd.step[2:0])
					3'd0: begin mul_a = 36'(e1_q[1]); mul_b = 26'(e2_q[2]); end
					3'd1: begin mul_a = 36'(e1_q[2]); mul_b = 26'(e2_q[1]); end
					3'd2: begin mul_a = 36'(e1_q[2]); mul_b = 26'(e2_q[0]); end
					3'd3: begin mul_a = 36'(e1_q[0]); mul_b = 26'(e2_q[2]); end
					3'd4: begin mul_a = 36'(e1_q[0]); mul_b = 26'(e2_q[1]); end
					3'd5: begin mul_a = 36'(e1_q[1]); mul_b = 26'(e2_q[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			OP_FLIP: begin
				mul_a = 36'(n_q[idx]);
				mul_b = 26'(r_q[idx]);
			end
			OP_SQ: begin
				mul_a = vec_q[idx];
				mul_b = 26'(vec_q[idx]);
			end
			OP_DOT: begin
				mul_a = vec_q[idx];
				mul_b = 26'(ns_q[idx]);
			end
			OP_DEN: begin
				mul_a = signed'({11'd0, ln_q});
				mul_b = signed'({1'b0, ll_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 62'(mul_a) * 62'(mul_b);

	// Accumulate products; cross product pairs subtract their second term
	always_comb begin
		if (cmd.op == OP_CROSS) begin
			clr  = !cmd.step[0];
			term = cmd.step[0] ? -prod : prod;
		end else begin
			clr  = (cmd.step == 5'd0);
			term = prod;
		end
		acc_nxt = (clr ? 62'sd0 : acc_q) + term;
	end

	// Find the largest component magnitude of the working vector
	always_comb begin
		mag0 = vec_q[0][35] ? 36'(-vec_q[0]) : 36'(vec_q[0]);
		mag1 = vec_q[1][35] ? 36'(-vec_q[1]) : 36'(vec_q[1]);
		mag2 = vec_q[2][35] ? 36'(-vec_q[2]) : 36'(vec_q[2]);
		vmax = mag0;
		if (mag1 > vmax) vmax = mag1;
		if (mag2 > vmax) vmax = mag2;
		v_lo = vmax < (36'd1 << 22);
		v_hi = vmax >= (36'd1 << 23);
	end

	// One square root digit per cycle
	always_comb begin
		sq_t   = sr_q + sb_q;
		sq_ge  = sx_q >= sq_t;
		sr_nxt = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
	end

	assign lp      = light_pos[cmd.light];
	assign dot_mag = dot_q[49] ? 50'(-dot_q) : 50'(dot_q);
	assign den_u   = prod[61:0];
	assign q_clip  = (quo_q > 14'(ONE_Q12)) ? 14'(ONE_Q12) : quo_q;
	assign dot_nxt = flip_q ? -acc_nxt[49:0] : acc_nxt[49:0];

	assign stat.in_range = !v_lo && !v_hi;
	assign stat.nzero    = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
	assign stat.rzero    = (r_q[0] == '0) && (r_q[1] == '0) && (r_q[2] == '0);
	assign stat.lzero    = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0);

	// Advance the datapath registers as commanded
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				a_q[0]  <= vert_a_x;
				a_q[1]  <= vert_a_y;
				a_q[2]  <= vert_a_z;
				e1_q[0] <= 17'(vert_b_x) - 17'(vert_a_x);
				e1_q[1] <= 17'(vert_b_y) - 17'(vert_a_y);
				e1_q[2] <= 17'(vert_b_z) - 17'(vert_a_z);
				e2_q[0] <= 17'(vert_c_x) - 17'(vert_a_x);
				e2_q[1] <= 17'(vert_c_y) - 17'(vert_a_y);
				e2_q[2] <= 17'(vert_c_z) - 17'(vert_a_z);
				r_q[0]  <= 17'(center_x) - 17'(vert_a_x);
				r_q[1]  <= 17'(center_y) - 17'(vert_a_y);
				r_q[2]  <= 17'(center_z) - 17'(vert_a_z);
				sum_q   <= '0;
				degen_q <= 1'b0;
			end
			OP_CROSS: begin
				acc_q <= acc_nxt;
				if (cmd.step[0]) n_q[cmd.step[2:1]] <= acc_nxt[34:0];
			end
			OP_FLIP: begin
				acc_q <= acc_nxt;
				if (cmd.step == 5'd2) flip_q <= acc_nxt > 62'sd0;
			end
			OP_LOADN: begin
				vec_q[0] <= 36'(n_q[0]);
				vec_q[1] <= 36'(n_q[1]);
				vec_q[2] <= 36'(n_q[2]);
			end
			OP_LOADL: begin
				vec_q[0] <= 36'(signed'(lp[15:0]))  - 36'(a_q[0]);
				vec_q[1] <= 36'(signed'(lp[31:16])) - 36'(a_q[1]);
				vec_q[2] <= 36'(signed'(lp[47:32])) - 36'(a_q[2]);
			end
			OP_SCALE: begin
				if (v_lo) begin
					vec_q[0] <= vec_q[0] <<< 1;
					vec_q[1] <= vec_q[1] <<< 1;
					vec_q[2] <= vec_q[2] <<< 1;
				end else if (v_hi) begin
					vec_q[0] <= vec_q[0] >>> 1;
					vec_q[1] <= vec_q[1] >>> 1;
					vec_q[2] <= vec_q[2] >>> 1;
				end
			end
			OP_SQ: begin
				acc_q <= acc_nxt;
				if (!cmd.which && cmd.step == 5'd0) begin
					ns_q[0] <= 24'(vec_q[0]);
					ns_q[1] <= 24'(vec_q[1]);
					ns_q[2] <= 24'(vec_q[2]);
				end
				if (cmd.step == 5'd2) begin
					sx_q <= acc_nxt[49:0];
					sr_q <= '0;
					sb_q <= 50'd1 << 48;
				end
			end
			OP_SQRT: begin
				if (sq_ge) sx_q <= sx_q - sq_t;
				sr_q <= sr_nxt;
				sb_q <= sb_q >> 2;
				if (cmd.step == 5'd0) begin
					if (cmd.which) ll_q <= sr_nxt[24:0];
					else           ln_q <= sr_nxt[24:0];
				end
			end
			OP_DOT: begin
				acc_q <= acc_nxt;
				if (cmd.step == 5'd2) dot_q <= dot_nxt;
			end
			OP_DEN: begin
				rem_q <= {dot_mag, 12'd0} + (den_u >> 1);
				dsh_q <= den_u << 13;
				quo_q <= '0;
			end
			OP_DIV: begin
				if (rem_q >= dsh_q) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[12:0], rem_q >= dsh_q};
				dsh_q <= dsh_q >> 1;
			end
			OP_ACC: begin
				sum_q <= dot_q[49] ? sum_q - 18'(q_clip) : sum_q + 18'(q_clip);
			end
			OP_DEGEN: begin
				degen_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Saturate the sum to the output range
	always_comb begin
		if (sum_q > 18'sd32767)       intensity = 16'sh7FFF;
		else if (sum_q < -18'sd32768) intensity = -16'sh8000;
		else                          intensity = 16'(sum_q);
	end

	assign degenerate = degen_q;

endmodule

FILE: hdl/lfs_ctrl.sv
// Controller: sequences normal, per-light passes and the result strobe
`timescale 1ns / 1ps
`include "lambert_face_shading_top_assert.svh"

module lfs_ctrl import lfs_pkg::*; #(
	parameter int MAX_LIGHTS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [2:0] light_count,
	input  lfs_stat_t  stat,
	output lfs_cmd_t   cmd
);

	localparam int NUM_LIGHTS = (MAX_LIGHTS < NUM_LIGHT_REGS) ? MAX_LIGHTS : NUM_LIGHT_REGS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_FLIP,
		ST_NLOAD,
		ST_SCALE,
		ST_SQ,
		ST_SQRT,
		ST_LIGHT,
		ST_LCHK,
		ST_DOT,
		ST_DEN,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic       which_q;
	logic [2:0] k_q;
	logic [2:0] cnt_q;
	logic       ldegen;

	assign ldegen = stat.nzero || stat.rzero || stat.lzero;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);

	// Decode the datapath command
	always_comb begin
		cmd.op    = OP_NONE;
		cmd.step  = step_q;
		cmd.which = which_q;
		cmd.light = k_q[1:0];
		case (state_q)
			ST_IDLE:  if (start) cmd.op = OP_LOAD;
			ST_CROSS: cmd.op = OP_CROSS;
			ST_FLIP:  cmd.op = OP_FLIP;
			ST_NLOAD: cmd.op = OP_LOADN;
			ST_SCALE: cmd.op = OP_SCALE;
			ST_SQ:    cmd.op = OP_SQ;
			ST_SQRT:  cmd.op = OP_SQRT;
			ST_LIGHT: if (k_q != cnt_q) cmd.op = OP_LOADL;
			ST_LCHK:  if (ldegen) cmd.op = OP_DEGEN;
			ST_DOT:   cmd.op = OP_DOT;
			ST_DEN:   cmd.op = OP_DEN;
			ST_DIV:   cmd.op = OP_DIV;
			ST_ACC:   cmd.op = OP_ACC;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Hold state and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			which_q <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CROSS;
						step_q  <= '0;
						k_q     <= '0;
						cnt_q   <= (light_count > 3'(NUM_LIGHTS)) ? 3'(NUM_LIGHTS) : light_count;
					end
				end
				ST_CROSS: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd5) begin
						state_q <= ST_FLIP;
						step_q  <= '0;
					end
				end
				ST_FLIP: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd2) begin
						state_q <= stat.nzero ? ST_LIGHT : ST_NLOAD;
						step_q  <= '0;
					end
				end
				ST_NLOAD: begin
					state_q <= ST_SCALE;
					which_q <= 1'b0;
				end
				ST_SCALE: begin
					if (stat.in_range) begin
						state_q <= ST_SQ;
						step_q  <= '0;
					end
				end
				ST_SQ: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd2) begin
						state_q <= ST_SQRT;
						step_q  <= SQRT_LAST_STEP;
					end
				end
				ST_SQRT: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd0) begin
						state_q <= which_q ? ST_DOT : ST_LIGHT;
						step_q  <= '0;
					end
				end
				ST_LIGHT: begin
					state_q <= (k_q == cnt_q) ? ST_DONE : ST_LCHK;
				end
				ST_LCHK: begin
					if (ldegen) begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_LIGHT;
					end else begin
						which_q <= 1'b1;
						state_q <= ST_SCALE;
					end
				end
				ST_DOT: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd2) begin
						state_q <= ST_DEN;
						step_q  <= '0;
					end
				end
				ST_DEN: begin
					state_q <= ST_DIV;
					step_q  <= DIV_LAST_STEP;
				end
				ST_DIV: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd0) begin
						state_q <= ST_ACC;
						step_q  <= '0;
					end
				end
				ST_ACC: begin
					k_q     <= k_q + 3'd1;
					state_q <= ST_LIGHT;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LFS_ASSERT_NXT(a_done_pulse, done, !done)
	`LFS_ASSERT_IMP(a_load_on_accept, cmd.op == OP_LOAD, start && !busy)
	`LFS_ASSERT_IMP(a_light_bound, busy, k_q <= cnt_q)

endmodule

FILE: hdl/lambert_face_shading_top.sv
// Top level: configuration registers, controller and datapath of the face shader
//
//   channel   direction  handshake           payload
//   triangle  in         start & !busy       vert_a_x .. vert_c_z
//   result    out        done (one cycle)    intensity, degenerate
//   config    in         cfg_we              cfg_addr, cfg_wdata
//
// One face runs load, cross product and orientation, then the normal length
// when the normal is nonzero, then per light a check alone when its term is
// zeroed, else single-bit scaling of that vector, its length, the dot product
// and the divide, then a finish step.
// The 25-step square root and 14-step divider are shared by all lights.
// Reset clears the controller and sets the configuration registers to their reset values.
// done is high for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module lambert_face_shading_top import lfs_pkg::*; #(
	parameter int MAX_LIGHTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] vert_a_x,
	input  logic signed [15:0] vert_a_y,
	input  logic signed [15:0] vert_a_z,
	input  logic signed [15:0] vert_b_x,
	input  logic signed [15:0] vert_b_y,
	input  logic signed [15:0] vert_b_z,
	input  logic signed [15:0] vert_c_x,
	input  logic signed [15:0] vert_c_y,
	input  logic signed [15:0] vert_c_z,
	output logic               done,
	output logic signed [15:0] intensity,
	output logic               degenerate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [47:0]        cfg_wdata
);

	logic [2:0]         light_count_q;
	logic signed [15:0] center_x_q, center_y_q, center_z_q;
	logic [3:0][47:0]   light_pos_q;
	lfs_cmd_t           cmd;
	lfs_stat_t          stat;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_count_q <= 3'd1;
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
			light_pos_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LIGHT_COUNT: light_count_q  <= cfg_wdata[2:0];
				REG_CENTER_X:    center_x_q     <= cfg_wdata[15:0];
				REG_CENTER_Y:    center_y_q     <= cfg_wdata[15:0];
				REG_CENTER_Z:    center_z_q     <= cfg_wdata[15:0];
				REG_LIGHT_0:     light_pos_q[0] <= cfg_wdata;
				REG_LIGHT_1:     light_pos_q[1] <= cfg_wdata;
				REG_LIGHT_2:     light_pos_q[2] <= cfg_wdata;
				REG_LIGHT_3:     light_pos_q[3] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lfs_ctrl #(
		.MAX_LIGHTS(MAX_LIGHTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.light_count (light_count_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	lfs_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.stat       (stat),
		.vert_a_x   (vert_a_x),
		.vert_a_y   (vert_a_y),
		.vert_a_z   (vert_a_z),
		.vert_b_x   (vert_b_x),
		.vert_b_y   (vert_b_y),
		.vert_b_z   (vert_b_z),
		.vert_c_x   (vert_c_x),
		.vert_c_y   (vert_c_y),
		.vert_c_z   (vert_c_z),
		.center_x   (center_x_q),
		.center_y   (center_y_q),
		.center_z   (center_z_q),
		.light_pos  (light_pos_q),
		.intensity  (intensity),
		.degenerate (degenerate)
	);

endmodule

FILE: tb/tb.sv
// Testbench for the face shading block: directed and random triangles checked against a predictor
`timescale 1ns / 1ps

class shade_board;
	logic signed [15:0] want_int[$];
	logic               want_deg[$];
	int                 errors;

	function new();
		errors = 0;
	endfunction

	// note the expected word of an accepted triangle
	function void note_face(logic signed [15:0] i, logic d);
		want_int = {want_int, i};
		want_deg = {want_deg, d};
	endfunction

	// compare a result word with the oldest expectation
	function void check_word(logic signed [15:0] i, logic d);
		logic signed [15:0] ei;
		logic               ed;
		if (want_int.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: intensity %0d degenerate %0d", i, d);
			return;
		end
		ei = want_int.pop_front();
		ed = want_deg.pop_front();
		if (ei !== i || ed !== d) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: intensity exp %0d got %0d, degenerate exp %0d got %0d",
					ei, i, ed, d);
		end
	endfunction

	function int pending();
		return want_int.size();
	endfunction
endclass

module tb;
	import lfs_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] vert[9];
	logic               done;
	logic signed [15:0] intensity;
	logic               degenerate;
	logic               cfg_we;
	logic [2:0]         cfg_addr;
	logic [47:0]        cfg_wdata;

	// shadow of the configuration registers
	logic [2:0]  sh_count;
	logic [15:0] sh_center[3];
	logic [47:0] sh_light[4];

	shade_board board;
	bit         calm;

	lambert_face_shading_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vert_a_x(vert[0]), .vert_a_y(vert[1]), .vert_a_z(vert[2]),
		.vert_b_x(vert[3]), .vert_b_y(vert[4]), .vert_b_z(vert[5]),
		.vert_c_x(vert[6]), .vert_c_y(vert[7]), .vert_c_z(vert[8]),
		.done(done), .intensity(intensity), .degenerate(degenerate),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint fold_half(longint x);
		return x >>> 1;
	endfunction

	// scale a vector until its largest magnitude lies in [2^22, 2^23)
	function automatic void fit_range(ref longint v[3]);
		longint m;
		forever begin
			m = 0;
			for (int i = 0; i < 3; i++) begin
				if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
			end
			if (m < (64'sd1 <<< 22)) begin
				for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
			end else if (m >= (64'sd1 <<< 23)) begin
				for (int i = 0; i < 3; i++) v[i] = fold_half(v[i]);
			end else begin
				return;
			end
		end
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned length_of(longint v[3]);
		return root_floor(longint'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
	endfunction

	// flat Lambert intensity of one triangle under the shadowed configuration
	function automatic void shade_face(logic signed [15:0] p[9],
			output logic signed [15:0] lum, output logic deg);
		longint a[3], e1[3], e2[3], n[3], r[3], l[3], dotp, sum;
		longint unsigned ln, ll, num, den, q;
		bit flip, nz, rz;
		int cnt;
		sum = 0;
		deg = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = p[i];
			e1[i] = longint'(p[3 + i]) - a[i];
			e2[i] = longint'(p[6 + i]) - a[i];
			r[i] = longint'($signed(sh_center[i])) - a[i];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		nz = n[0] == 0 && n[1] == 0 && n[2] == 0;
		rz = r[0] == 0 && r[1] == 0 && r[2] == 0;
		flip = (n[0] * r[0] + n[1] * r[1] + n[2] * r[2]) > 0;
		ln = 0;
		if (!nz) begin
			fit_range(n);
			ln = length_of(n);
		end
		cnt = sh_count > 4 ? 4 : sh_count;
		for (int k = 0; k < cnt; k++) begin
			for (int i = 0; i < 3; i++)
				l[i] = longint'($signed(sh_light[k][16 * i +: 16])) - a[i];
			if (nz || rz || (l[0] == 0 && l[1] == 0 && l[2] == 0)) begin
				deg = 1'b1;
				continue;
			end
			fit_range(l);
			ll = length_of(l);
			dotp = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
			if (flip) dotp = -dotp;
			num = longint'(dotp < 0 ? -dotp : dotp) * ONE_Q12;
			den = ln * ll;
			q = den != 0 ? (num + den / 2) / den : 0;
			if (q > ONE_Q12) q = ONE_Q12;
			sum += dotp < 0 ? -longint'(q) : longint'(q);
		end
		if (sum > 32767) sum = 32767;
		if (sum < -32768) sum = -32768;
		lum = sum[15:0];
	endfunction

	// check every result word at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done) board.check_word(intensity, degenerate);
	end

	task automatic idle_burst();
		if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LIGHT_COUNT: sh_count = val[2:0];
			REG_CENTER_X:    sh_center[0] = val[15:0];
			REG_CENTER_Y:    sh_center[1] = val[15:0];
			REG_CENTER_Z:    sh_center[2] = val[15:0];
			default:         sh_light[2'(idx - REG_LIGHT_0)] = val;
		endcase
	endtask

	// drain all expectations, then let the block settle
	task automatic settle();
		while (board.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// offer one triangle and hold it until accepted
	task automatic send_face(logic signed [15:0] p[9]);
		logic signed [15:0] lum;
		logic               deg;
		idle_burst();
		vert = p;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		shade_face(p, lum, deg);
		board.note_face(lum, deg);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic logic signed [15:0] pick_coord(int spread);
		case ($urandom_range(0, 9))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh0000;
			default: return spread == 0 ? 16'($urandom) :
				16'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	task automatic random_setting(int spread);
		write_reg(REG_LIGHT_COUNT, 48'($urandom_range(0, 7)));
		for (int i = 0; i < 3; i++) write_reg(3'(REG_CENTER_X + i), 48'(pick_coord(spread)));
		for (int k = 0; k < 4; k++)
			write_reg(3'(REG_LIGHT_0 + k),
				{pick_coord(spread), pick_coord(spread), pick_coord(spread)});
	endtask

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic signed [15:0] p[9];
		int spread;
		board = new();
		calm = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		for (int i = 0; i < 9; i++) vert[i] = '0;
		sh_count = 3'd1;
		for (int i = 0; i < 3; i++) sh_center[i] = '0;
		for (int k = 0; k < 4; k++) sh_light[k] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset setting, a flat triangle, a vertex on the center
		p = '{16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0};
		send_face(p);
		p = '{16'sd16, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd5};
		send_face(p);
		p = '{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd9, 16'sd9, 16'sd9};
		send_face(p);
		settle();

		// directed: four lights around a center, normals both ways
		write_reg(REG_LIGHT_COUNT, 48'd4);
		write_reg(REG_CENTER_X, 48'hffc0);
		write_reg(REG_CENTER_Y, 48'd100);
		write_reg(REG_CENTER_Z, 48'd0);
		write_reg(REG_LIGHT_0, {16'sd0, 16'sd0, 16'sd1600});
		write_reg(REG_LIGHT_1, {16'sd800, 16'sh8000, 16'sh7fff});
		write_reg(REG_LIGHT_2, {16'sh7fff, 16'sh7fff, 16'sh7fff});
		write_reg(REG_LIGHT_3, {16'sd0, 16'sd0, 16'sd0});
		p = '{16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0};
		send_face(p);
		p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd0};
		send_face(p);
		p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh7fff};
		send_face(p);
		p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh8000};
		send_face(p);
		p = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
		send_face(p);
		settle();

		// directed: light count zero and beyond the registers
		write_reg(REG_LIGHT_COUNT, 48'd0);
		send_face(p);
		settle();
		write_reg(REG_LIGHT_COUNT, 48'd7);
		send_face(p);
		settle();

		// random phases with fresh settings; small spreads make lights line up
		for (int ph = 0; ph < 16; ph++) begin
			spread = ph % 4 == 0 ? 0 : (ph % 4 == 1 ? 8 : (ph % 4 == 2 ? 300 : 4000));
			random_setting(spread);
			if (ph >= 13) calm = 1'b1;
			for (int n = 0; n < 50; n++) begin
				for (int i = 0; i < 9; i++) p[i] = pick_coord(spread);
				if ($urandom_range(0, 15) == 0) begin
					for (int i = 0; i < 3; i++) p[3 + i] = p[i];
				end
				send_face(p);
			end
			settle();
		end

		if (board.errors == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
